>>> rtl/core/mbba_pkg.sv
// ============================================================================
// mbba_pkg
// Shared types and constants of the multi-block bump allocator.
// ============================================================================
package mbba_pkg;

   // Field widths of the request and result items.
   localparam int SIZE_W   = 25;
   localparam int SHIFT_W  = 5;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;

   // Size of a newly opened block after reset.
   localparam logic [SIZE_W-1:0] RESET_BLOCK_BYTES = SIZE_W'(2 << 16);

   // Outcome of one request.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_PLACED    = 2'd0,
      STATUS_OPENED    = 2'd1,
      STATUS_TOO_LARGE = 2'd2,
      STATUS_NO_SLOT   = 2'd3
   } status_type;

   // Request token; walks the row one cell per cycle unless the row holds.
   typedef struct packed {
      logic                valid;
      logic                done;
      logic                too_large;
      logic [SIZE_W-1:0]   req_bytes;
      logic [SIZE_W-1:0]   align_mask;
      logic [INDEX_W-1:0]  block_index;
      logic [SIZE_W-1:0]   byte_offset;
      status_type          status;
   } token_type;

endpackage

>>> rtl/core/mbba_cell.sv
// ============================================================================
// mbba_cell
// One block slot: holds the block's size, fill level and open flag, and
// tries to place a passing request token before handing it to the next cell.
// ============================================================================
module mbba_cell
   import mbba_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [SIZE_W-1:0] block_bytes,
   input  token_type         token_in,
   output token_type         token_out
);

   logic              open_ff, open_in;
   logic [SIZE_W-1:0] fill_ff, fill_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   token_type         token_ff, token_in_next;

   logic [SIZE_W:0]   round_sum;
   logic [SIZE_W:0]   start;
   logic [SIZE_W+1:0] end_pos;
   logic              fits;
   logic              active;

   // Round the fill level up to the alignment and check the fit.
   always_comb begin
      round_sum = {1'b0, fill_ff} + {1'b0, token_in.align_mask};
      start     = round_sum & ~{1'b0, token_in.align_mask};
      end_pos   = {1'b0, start} + {2'b0, token_in.req_bytes};
      fits      = (end_pos <= {2'b0, size_ff});
   end

   // Place the request, open this slot, report too large, or pass it on.
   always_comb begin
      open_in       = open_ff;
      fill_in       = fill_ff;
      size_in       = size_ff;
      token_in_next = token_in;
      active        = advance && token_in.valid && !token_in.done;
      if (active) begin
         if (open_ff) begin
            if (fits) begin
               fill_in                   = end_pos[SIZE_W-1:0];
               token_in_next.done        = 1'b1;
               token_in_next.block_index = INDEX_W'(CELL_INDEX);
               token_in_next.byte_offset = start[SIZE_W-1:0];
               token_in_next.status      = STATUS_PLACED;
            end
         end else if (token_in.too_large) begin
            token_in_next.done        = 1'b1;
            token_in_next.block_index = '0;
            token_in_next.byte_offset = '0;
            token_in_next.status      = STATUS_TOO_LARGE;
         end else begin
            open_in                   = 1'b1;
            size_in                   = block_bytes;
            fill_in                   = token_in.req_bytes;
            token_in_next.done        = 1'b1;
            token_in_next.block_index = INDEX_W'(CELL_INDEX);
            token_in_next.byte_offset = '0;
            token_in_next.status      = STATUS_OPENED;
         end
      end
   end

   // Slot state and outgoing token; only the flags are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff        <= 1'b0;
         token_ff.valid <= 1'b0;
      end else if (advance) begin
         open_ff        <= open_in;
         token_ff.valid <= token_in_next.valid;
      end
      if (advance) begin
         fill_ff                <= fill_in;
         size_ff                <= size_in;
         token_ff.done          <= token_in_next.done;
         token_ff.too_large     <= token_in_next.too_large;
         token_ff.req_bytes     <= token_in_next.req_bytes;
         token_ff.align_mask    <= token_in_next.align_mask;
         token_ff.block_index   <= token_in_next.block_index;
         token_ff.byte_offset   <= token_in_next.byte_offset;
         token_ff.status        <= token_in_next.status;
      end
   end

   assign token_out = token_ff;

endmodule

>>> rtl/core/multi_block_bump_allocator.sv
// ============================================================================
// multi_block_bump_allocator
// First-fit bump allocator over a row of block slots.
// ============================================================================
// Usage:
//   A request item on req_ carries a byte count and an alignment exponent.
//   Exactly one result item leaves on rsp_ for each request: the block
//   index, the aligned offset and a status (placed, opened, too large,
//   no free slot). The block size for newly opened blocks is written on
//   csr_wr_en / csr_wr_data while the allocator is idle.
//   The request travels through a row of MAX_BLOCKS cells, one cell per
//   cycle while the row is not held; each cell holds one block's size and
//   fill level. The entry register and then every cell register the request
//   in turn, and a new request is taken only once the previous result is
//   registered, so only one item is in the row at a time.
//   A result waiting on rsp_ does not block the next request; only the
//   result after it waits, holding the whole row, until rsp_tready is high.
//   Synchronous reset closes every block, empties the row and restores the
//   block size to 131072 bytes.
// ============================================================================
module multi_block_bump_allocator
   import mbba_pkg::*;
#(
   parameter int MAX_BLOCKS = 16
) (
   input  logic              clock,
   input  logic              reset,
   // Request channel.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [24:0] request_bytes, [29:25] align_shift
   // Result channel.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [3:0] block_index, [28:4] byte_offset
   output logic [1:0]        rsp_tuser,   // [1:0] status
   // Configuration.
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   logic [SIZE_W-1:0]  block_bytes_ff;
   logic               busy_ff, busy_in;
   token_type          entry_ff, entry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [SIZE_W-1:0]  rsp_offset_ff;
   status_type         rsp_status_ff, final_status;

   logic [SIZE_W-1:0]  req_bytes;
   logic [SHIFT_W-1:0] align_shift;
   logic [SIZE_W-1:0]  align_mask;
   logic               accept;
   logic               advance;
   logic               load_rsp;

   token_type          links [0:MAX_BLOCKS];

   assign req_bytes   = req_tdata[SIZE_W-1:0];
   assign align_shift = req_tdata[SIZE_W+SHIFT_W-1:SIZE_W];
   assign req_tready  = !busy_ff;
   assign accept      = req_tvalid && !busy_ff;

   // The whole row holds while a finished item waits behind a stalled result.
   assign advance  = !(links[MAX_BLOCKS].valid && rsp_valid_ff && !rsp_tready);
   assign load_rsp = links[MAX_BLOCKS].valid && advance;

   // Alignment mask; shifts past the field width round any nonzero fill out of range.
   always_comb begin
      if (align_shift >= SHIFT_W'(SIZE_W)) begin
         align_mask = '1;
      end else begin
         align_mask = (SIZE_W'(1) << align_shift) - SIZE_W'(1);
      end
   end

   // Build the token that enters the row.
   always_comb begin
      entry_in             = entry_ff;
      if (advance) begin
         entry_in.valid       = accept;
         entry_in.done        = 1'b0;
         entry_in.too_large   = (req_bytes > block_bytes_ff);
         entry_in.req_bytes   = req_bytes;
         entry_in.align_mask  = align_mask;
         entry_in.block_index = '0;
         entry_in.byte_offset = '0;
         entry_in.status      = STATUS_NO_SLOT;
      end
   end

   // A finished token keeps its status; one never placed reports why.
   always_comb begin
      if (links[MAX_BLOCKS].done) begin
         final_status = links[MAX_BLOCKS].status;
      end else if (links[MAX_BLOCKS].too_large) begin
         final_status = STATUS_TOO_LARGE;
      end else begin
         final_status = STATUS_NO_SLOT;
      end
   end

   // Busy from acceptance until the result is registered.
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (load_rsp) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);
   end

   // Control registers and the entry token; only flags and the block size are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= RESET_BLOCK_BYTES;
         busy_ff        <= 1'b0;
         entry_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            block_bytes_ff <= csr_wr_data;
         end
         busy_ff        <= busy_in;
         entry_ff.valid <= entry_in.valid;
         rsp_valid_ff   <= rsp_valid_in;
      end
      entry_ff.done        <= entry_in.done;
      entry_ff.too_large   <= entry_in.too_large;
      entry_ff.req_bytes   <= entry_in.req_bytes;
      entry_ff.align_mask  <= entry_in.align_mask;
      entry_ff.block_index <= entry_in.block_index;
      entry_ff.byte_offset <= entry_in.byte_offset;
      entry_ff.status      <= entry_in.status;
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_index_ff  <= links[MAX_BLOCKS].done ? links[MAX_BLOCKS].block_index : '0;
         rsp_offset_ff <= links[MAX_BLOCKS].done ? links[MAX_BLOCKS].byte_offset : '0;
         rsp_status_ff <= final_status;
      end
   end

   // Row of block slots.
   assign links[0] = entry_ff;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      mbba_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .block_bytes (block_bytes_ff),
         .token_in    (links[i]),
         .token_out   (links[i+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_offset_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> tb/sv/tb_multi_block_bump_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_multi_block_bump_allocator
// Self-checking testbench of the first-fit multi-block bump allocator.
// ============================================================================
// Allocation requests are queued by a stimulus process and offered on req_
// by a clocked driver. A clocked monitor keeps its own copy of the block
// slots, works out the placement of every accepted request and checks each
// result item on rsp_ against the oldest outstanding placement. The block
// size is rewritten between phases while the allocator is idle, and both
// sides idle and stall at random.
// ============================================================================
module tb_multi_block_bump_allocator
   import mbba_pkg::*;
();

   localparam int MAX_BLOCKS    = 16;
   localparam int SETTLE_CYCLES = MAX_BLOCKS + 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 110;
   localparam int HOLD_AT       = 470;
   localparam int HOLD_CYCLES   = 300;

   // One allocation request, packed as it travels on req_tdata.
   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic [SIZE_W-1:0]  nbytes;
   } alloc_req_type;

   // One placement as the allocator should report it.
   typedef struct {
      logic [INDEX_W-1:0] block_index;
      logic [SIZE_W-1:0]  byte_offset;
      status_type         status;
   } placement_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [31:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_wr_en   = 1'b0;
   logic [SIZE_W-1:0] csr_wr_data = '0;

   alloc_req_type pending_reqs[$];
   placement_type expected_allocs[$];
   int         queued_count = 0;
   int         rsp_count    = 0;
   int         cycle_count  = 0;
   int         hold_left    = 0;
   bit         hold_done    = 0;
   bit         failed       = 0;
   logic       req_fired    = 1'b0;
   logic       steady;

   // Mirror of the allocator state.
   logic [SIZE_W-1:0] fill_level[MAX_BLOCKS];
   logic [SIZE_W-1:0] slot_bytes[MAX_BLOCKS];
   int unsigned       open_count;
   logic [SIZE_W-1:0] new_block_bytes;

   multi_block_bump_allocator #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Neither side idles for a stretch in the middle of the run.
   assign steady = (rsp_count >= 250) && (rsp_count < 340);

   // First-fit placement of one request; updates the mirrored slots.
   function automatic placement_type allocate(input logic [SIZE_W-1:0] nbytes,
                                              input logic [SHIFT_W-1:0] shift);
      placement_type p;
      logic [63:0]   mask;
      logic [63:0]   start;
      p.block_index = '0;
      p.byte_offset = '0;
      p.status      = STATUS_PLACED;
      mask = (64'd1 << shift) - 64'd1;
      for (int i = 0; i < open_count; i++) begin
         start = (64'(fill_level[i]) + mask) & ~mask;
         if (start + 64'(nbytes) <= 64'(slot_bytes[i])) begin
            fill_level[i] = SIZE_W'(start + 64'(nbytes));
            p.block_index = INDEX_W'(i);
            p.byte_offset = SIZE_W'(start);
            return p;
         end
      end
      if (nbytes > new_block_bytes) begin
         p.status = STATUS_TOO_LARGE;
      end else if (open_count >= MAX_BLOCKS) begin
         p.status = STATUS_NO_SLOT;
      end else begin
         slot_bytes[open_count] = new_block_bytes;
         fill_level[open_count] = nbytes;
         p.block_index = INDEX_W'(open_count);
         p.status      = STATUS_OPENED;
         open_count++;
      end
      return p;
   endfunction

   // Random request scaled to the current block size, with some noise.
   function automatic alloc_req_type random_request(input logic [SIZE_W-1:0] bb);
      alloc_req_type r;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      r.shift = SHIFT_W'($urandom_range(0, 8));
      if (pick < 65) begin
         r.nbytes = SIZE_W'($urandom_range(0, (bb >> 5) + 1));
      end else if (pick < 75) begin
         r.nbytes = SIZE_W'($urandom_range(0, bb));
      end else if (pick < 80) begin
         r.nbytes = bb;
      end else if (pick < 84) begin
         r.nbytes = bb + SIZE_W'(1);
      end else if (pick < 88) begin
         r.nbytes = '0;
      end else begin
         r.nbytes = SIZE_W'($urandom);
         r.shift  = SHIFT_W'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
         r.shift = SHIFT_W'($urandom_range(9, 31));
      end
      return r;
   endfunction

   // Request driver: holds an item until it is taken, then maybe idles.
   always @(negedge clock) begin
      alloc_req_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 36)) begin
            next_req = pending_reqs.pop_front();
            req_tdata  <= {2'b00, next_req};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result ready: random stalls, plus one long hold-off to back up the row.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && rsp_count == HOLD_AT) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 36);
      end
   end

   // Monitor: mirrors register writes, predicts requests, checks results.
   always @(posedge clock) begin
      placement_type want;
      req_fired <= req_tvalid && req_tready;
      if (reset) begin
         open_count      = 0;
         new_block_bytes = RESET_BLOCK_BYTES;
      end else begin
         if (csr_wr_en) begin
            new_block_bytes = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            if (expected_allocs.size() == 0) begin
               $display("%0t: unexpected result item, index %0d offset %0d status %0d",
                        $time, rsp_tdata[3:0], rsp_tdata[28:4], rsp_tuser);
               failed = 1;
            end else begin
               want = expected_allocs.pop_front();
               if (rsp_tdata[3:0] !== want.block_index) begin
                  $display("%0t: block_index mismatch, expected %0d, actual %0d",
                           $time, want.block_index, rsp_tdata[3:0]);
                  failed = 1;
               end
               if (rsp_tdata[28:4] !== want.byte_offset) begin
                  $display("%0t: byte_offset mismatch, expected %0d, actual %0d",
                           $time, want.byte_offset, rsp_tdata[28:4]);
                  failed = 1;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_tuser);
                  failed = 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_allocs.insert(expected_allocs.size(),
                                   allocate(req_tdata[24:0], req_tdata[29:25]));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_req(input int unsigned nbytes, input int unsigned shift);
      alloc_req_type r;
      r.nbytes = SIZE_W'(nbytes);
      r.shift  = SHIFT_W'(shift);
      pending_reqs.insert(pending_reqs.size(), r);
      queued_count++;
   endtask

   // Waits until every queued request has returned its result.
   task automatic drain();
      while (rsp_count != queued_count) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_block_bytes(input logic [SIZE_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus.
   initial begin
      logic [SIZE_W-1:0] bb;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset block size.
      queue_req(0, 0);            // zero bytes open the first block
      queue_req(100, 3);
      queue_req(1, 31);           // huge alignment misses, new block
      queue_req(0, 16);           // zero bytes moved to an aligned start
      queue_req(16777216, 0);     // too large
      queue_req(33554431, 31);    // too large, every bit set
      queue_req(131072, 0);       // exactly one block
      queue_req(65536, 16);       // fills block 0 to its end
      queue_req(0, 0);            // zero bytes at the very end of a block

      // Empty blocks.
      write_block_bytes('0);
      queue_req(0, 31);
      queue_req(1, 31);
      queue_req(0, 5);

      // Smallest nonzero block.
      write_block_bytes(SIZE_W'(1));
      queue_req(1, 31);
      queue_req(2, 0);

      // A 16777216-byte block.
      write_block_bytes(SIZE_W'(16777216));
      queue_req(16777216, 0);
      queue_req(16777217, 0);

      // Random phases, each with its own block size.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: bb = SIZE_W'(65536);
            1: bb = SIZE_W'($urandom_range(256, 8192));
            2: bb = SIZE_W'(16777216);
            3: bb = SIZE_W'($urandom_range(1, 16777216));
            4: bb = {SIZE_W{1'b1}};
            5: bb = SIZE_W'($urandom_range(16, 1024));
            default: bb = SIZE_W'(131072);
         endcase
         write_block_bytes(bb);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pending_reqs.insert(pending_reqs.size(), random_request(bb));
            queued_count++;
         end
      end

      // Use up the remaining slots, then run into the full condition.
      write_block_bytes(SIZE_W'(1));
      for (int n = 0; n < 20; n++) begin
         queue_req(1, 31);
      end

      // Random tail with every slot in use.
      bb = SIZE_W'($urandom_range(1, 65536));
      write_block_bytes(bb);
      for (int n = 0; n < 30; n++) begin
         pending_reqs.insert(pending_reqs.size(), random_request(bb));
         queued_count++;
      end

      drain();
      if (!failed && expected_allocs.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
